// ----- sv/hsfd_pkg.sv -----
package hsfd_pkg;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_beat_t;

  typedef struct packed {
    logic signed [14:0] temperature_centi_c;
    logic [13:0]        humidity_centi_pct;
    logic [15:0]        raw_temperature;
    logic [15:0]        raw_humidity;
    logic [1:0]         frame_status;
  } out_beat_t;

  typedef logic [2:0] byte_pos_t;

  localparam byte_pos_t POS_TEMP_HI  = 3'd0;
  localparam byte_pos_t POS_TEMP_LO  = 3'd1;
  localparam byte_pos_t POS_TEMP_CRC = 3'd2;
  localparam byte_pos_t POS_HUM_HI   = 3'd3;
  localparam byte_pos_t POS_HUM_LO   = 3'd4;
  localparam byte_pos_t POS_HUM_CRC  = 3'd5;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_TEMP_CRC = 2'd1;
  localparam logic [1:0] STATUS_HUM_CRC  = 2'd2;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  localparam logic [14:0]        TEMP_SPAN   = 15'd17500;
  localparam logic [13:0]        HUM_SPAN    = 14'd10000;
  localparam logic signed [14:0] TEMP_OFFSET = -15'sd4500;
  localparam logic [16:0]        WORD_MAX    = 17'd65535;
  localparam logic [13:0]        HUM_LIMIT   = 14'd10000;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- sv/humidity_sensor_frame_decoder.sv -----
// Humidity sensor frame decoder.
// The input channel carries one received byte per beat, with frame_start
// marking the first byte of a six-byte frame: temperature high, low, CRC,
// humidity high, low, CRC. Each CRC is CRC-8, polynomial 0x31, init 0xFF.
// After the sixth byte one beat leaves on the output channel with both raw
// words, temperature in hundredths of a degree, humidity in hundredths of a
// percent and a status; on a CRC mismatch the converted values are zero.
// Without a start mark the byte after a complete frame begins the next one.
// A byte is accepted in every cycle in which in_ready is high. After the
// sixth byte is accepted the result passes through one register stage that
// holds the two constant products, then the output register, which holds
// the quotients by 65535, formed with one add and one compare each.
// Reset returns the byte position to the first byte, sets the running CRC to 0xFF and clears both valid flags.
// When the receiver stalls, the output register and the product stage hold
// their beats; bytes keep being accepted until both are full, then
// in_ready drops.
module humidity_sensor_frame_decoder
  import hsfd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  byte_pos_t   byte_position;
  logic [7:0]  running_check;
  logic [15:0] temperature_word;
  logic        temperature_check_ok;
  logic [7:0]  humidity_high_byte;
  logic [7:0]  humidity_low_byte;

  logic        p_valid;
  logic [30:0] p_temp_prod;
  logic [29:0] p_hum_prod;
  logic [15:0] p_raw_t;
  logic [15:0] p_raw_h;
  logic [1:0]  p_status;

  logic        in_fire;
  logic        out_free;
  logic        p_free;
  byte_pos_t   pos;
  logic [7:0]  crc_next;
  logic [15:0] raw_h;
  logic [1:0]  status_next;

  logic [14:0] t_q0;
  logic [16:0] t_r;
  logic [14:0] t_q;
  logic [13:0] h_q0;
  logic [16:0] h_r;
  logic [13:0] h_q;

  assign out_free = !out_valid || out_ready;
  assign p_free   = !p_valid || out_free;
  assign in_ready = p_free;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    if (in_data.frame_start || byte_position > POS_HUM_CRC) begin
      pos = POS_TEMP_HI;
    end else begin
      pos = byte_position;
    end
    if (pos == POS_TEMP_HI || pos == POS_HUM_HI) begin
      crc_next = crc8_update(CRC_INIT, in_data.rx_byte);
    end else begin
      crc_next = crc8_update(running_check, in_data.rx_byte);
    end
    raw_h = {humidity_high_byte, humidity_low_byte};
    if (!temperature_check_ok) begin
      status_next = STATUS_TEMP_CRC;
    end else if (running_check != in_data.rx_byte) begin
      status_next = STATUS_HUM_CRC;
    end else begin
      status_next = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position        <= POS_TEMP_HI;
      running_check        <= CRC_INIT;
      temperature_word     <= '0;
      temperature_check_ok <= 1'b0;
      humidity_high_byte   <= '0;
      humidity_low_byte    <= '0;
    end else if (in_fire) begin
      byte_position <= (pos == POS_HUM_CRC) ? POS_TEMP_HI : pos + 3'd1;
      case (pos)
        POS_TEMP_HI: begin
          running_check    <= crc_next;
          temperature_word <= {in_data.rx_byte, 8'h00};
        end
        POS_TEMP_LO: begin
          running_check    <= crc_next;
          temperature_word <= {temperature_word[15:8], in_data.rx_byte};
        end
        POS_TEMP_CRC: begin
          temperature_check_ok <= (running_check == in_data.rx_byte);
        end
        POS_HUM_HI: begin
          running_check      <= crc_next;
          humidity_high_byte <= in_data.rx_byte;
        end
        POS_HUM_LO: begin
          running_check     <= crc_next;
          humidity_low_byte <= in_data.rx_byte;
        end
        POS_HUM_CRC: begin
          running_check <= CRC_INIT;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (p_free) begin
      p_valid <= in_fire && pos == POS_HUM_CRC;
    end
  end

  always_ff @(posedge clk) begin
    if (p_free && in_fire && pos == POS_HUM_CRC) begin
      p_temp_prod <= 31'(temperature_word) * 31'(TEMP_SPAN);
      p_hum_prod  <= 30'(raw_h) * 30'(HUM_SPAN);
      p_raw_t     <= temperature_word;
      p_raw_h     <= raw_h;
      p_status    <= status_next;
    end
  end

  // x / 65535 for x below 65535 * 65536: x = q0 * 65535 + (q0 + x mod 65536),
  // and that remainder stays below twice the divisor.
  always_comb begin
    t_q0 = p_temp_prod[30:16];
    t_r  = 17'(p_temp_prod[15:0]) + 17'(t_q0);
    t_q  = t_q0 + 15'(t_r >= WORD_MAX);
    h_q0 = p_hum_prod[29:16];
    h_r  = 17'(p_hum_prod[15:0]) + 17'(h_q0);
    h_q  = h_q0 + 14'(h_r >= WORD_MAX);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && p_valid) begin
      out_data.raw_temperature <= p_raw_t;
      out_data.raw_humidity    <= p_raw_h;
      out_data.frame_status    <= p_status;
      if (p_status == STATUS_OK) begin
        out_data.temperature_centi_c <= $signed(t_q) + TEMP_OFFSET;
        out_data.humidity_centi_pct  <= h_q;
      end else begin
        out_data.temperature_centi_c <= '0;
        out_data.humidity_centi_pct  <= '0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    byte_position <= POS_HUM_CRC)
    else $error("byte position left the frame");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    p_valid && out_valid && !out_ready |=> p_valid && $stable(p_status))
    else $error("product stage lost a beat under stall");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.frame_status != STATUS_OK |->
      out_data.temperature_centi_c == '0 && out_data.humidity_centi_pct == '0)
    else $error("converted values not zero on CRC mismatch");

  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.frame_status == STATUS_OK |->
      out_data.humidity_centi_pct <= HUM_LIMIT)
    else $error("humidity above full scale");
`endif

endmodule

// ----- verif/tb_humidity_sensor_frame_decoder.sv -----
module tb_humidity_sensor_frame_decoder;
  import hsfd_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned PHASE_BYTES = 333;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;

  in_beat_t    pending_bytes[$];
  out_beat_t   expected_readings[$];
  int unsigned bytes_queued = 0;
  int unsigned bytes_taken = 0;
  int unsigned src_idle_pct = 29;
  int unsigned sink_idle_pct = 80;
  int unsigned stall_cycles = 0;
  bit          in_fire = 1'b0;
  bit          failed = 1'b0;

  byte_pos_t   next_pos = POS_TEMP_HI;
  logic [7:0]  word_crc = CRC_INIT;
  logic [15:0] temp_word = '0;
  logic        temp_crc_ok = 1'b0;
  logic [7:0]  hum_hi = '0;
  logic [7:0]  hum_lo = '0;

  humidity_sensor_frame_decoder u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] data);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ data[i];
      c = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return c;
  endfunction

  task automatic decode_byte(in_beat_t beat);
    byte_pos_t   pos;
    out_beat_t   reading;
    int unsigned raw_t;
    int unsigned raw_h;
    int          temp_val;
    int unsigned hum_val;
    pos = next_pos;
    if (beat.frame_start || pos > POS_HUM_CRC) begin
      pos = POS_TEMP_HI;
    end
    next_pos = pos + 3'd1;
    case (pos)
      POS_TEMP_HI: begin
        word_crc = crc8_step(CRC_INIT, beat.rx_byte);
        temp_word = {beat.rx_byte, 8'h00};
      end
      POS_TEMP_LO: begin
        word_crc = crc8_step(word_crc, beat.rx_byte);
        temp_word[7:0] = beat.rx_byte;
      end
      POS_TEMP_CRC: begin
        temp_crc_ok = (word_crc == beat.rx_byte);
      end
      POS_HUM_HI: begin
        word_crc = crc8_step(CRC_INIT, beat.rx_byte);
        hum_hi = beat.rx_byte;
      end
      POS_HUM_LO: begin
        word_crc = crc8_step(word_crc, beat.rx_byte);
        hum_lo = beat.rx_byte;
      end
      default: begin
        raw_t = 32'(temp_word);
        raw_h = 32'({hum_hi, hum_lo});
        reading = '0;
        reading.raw_temperature = temp_word;
        reading.raw_humidity = {hum_hi, hum_lo};
        if (!temp_crc_ok) begin
          reading.frame_status = STATUS_TEMP_CRC;
        end else if (word_crc != beat.rx_byte) begin
          reading.frame_status = STATUS_HUM_CRC;
        end else begin
          reading.frame_status = STATUS_OK;
          temp_val = -4500 + int'((32'd17500 * raw_t) / 32'd65535);
          hum_val = (32'd10000 * raw_h) / 32'd65535;
          reading.temperature_centi_c = temp_val[14:0];
          reading.humidity_centi_pct = hum_val[13:0];
        end
        expected_readings.push_back(reading);
        next_pos = POS_TEMP_HI;
        word_crc = CRC_INIT;
      end
    endcase
  endtask

  task automatic check_reading(out_beat_t want, out_beat_t got);
    if (got.temperature_centi_c !== want.temperature_centi_c) begin
      $display("%0t: temperature_centi_c expected %0d got %0d", $time,
               want.temperature_centi_c, got.temperature_centi_c);
      failed = 1'b1;
    end
    if (got.humidity_centi_pct !== want.humidity_centi_pct) begin
      $display("%0t: humidity_centi_pct expected %0d got %0d", $time,
               want.humidity_centi_pct, got.humidity_centi_pct);
      failed = 1'b1;
    end
    if (got.raw_temperature !== want.raw_temperature) begin
      $display("%0t: raw_temperature expected %h got %h", $time,
               want.raw_temperature, got.raw_temperature);
      failed = 1'b1;
    end
    if (got.raw_humidity !== want.raw_humidity) begin
      $display("%0t: raw_humidity expected %h got %h", $time,
               want.raw_humidity, got.raw_humidity);
      failed = 1'b1;
    end
    if (got.frame_status !== want.frame_status) begin
      $display("%0t: frame_status expected %0d got %0d", $time,
               want.frame_status, got.frame_status);
      failed = 1'b1;
    end
  endtask

  task automatic queue_byte(logic [7:0] data, logic start);
    in_beat_t beat;
    beat.rx_byte = data;
    beat.frame_start = start;
    pending_bytes.push_back(beat);
    bytes_queued++;
  endtask

  task automatic queue_frame(logic [15:0] raw_t, logic [15:0] raw_h, logic start,
                             bit bad_t, bit bad_h, int unsigned nbytes);
    logic [7:0] frame[6];
    frame[0] = raw_t[15:8];
    frame[1] = raw_t[7:0];
    frame[2] = crc8_step(crc8_step(CRC_INIT, frame[0]), frame[1]);
    frame[3] = raw_h[15:8];
    frame[4] = raw_h[7:0];
    frame[5] = crc8_step(crc8_step(CRC_INIT, frame[3]), frame[4]);
    if (bad_t) begin
      frame[2] ^= 8'($urandom_range(255, 1));
    end
    if (bad_h) begin
      frame[5] ^= 8'($urandom_range(255, 1));
    end
    for (int i = 0; i < nbytes; i++) begin
      queue_byte(frame[i], (i == 0) ? start : 1'b0);
    end
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  task automatic queue_random(int unsigned count);
    int unsigned added;
    int unsigned kind;
    int unsigned n;
    bit          need_start;
    logic        start;
    added = 0;
    need_start = 1'b1;
    while (added < count) begin
      kind = $urandom_range(99);
      start = need_start || ($urandom_range(3) != 0);
      need_start = 1'b0;
      n = 6;
      if (kind < 70) begin
        queue_frame(pick_word(), pick_word(), start, 1'b0, 1'b0, n);
      end else if (kind < 78) begin
        queue_frame(pick_word(), pick_word(), start, 1'b1, 1'b0, n);
      end else if (kind < 86) begin
        queue_frame(pick_word(), pick_word(), start, 1'b0, 1'b1, n);
      end else if (kind < 90) begin
        queue_frame(pick_word(), pick_word(), start, 1'b1, 1'b1, n);
      end else if (kind < 95) begin
        n = $urandom_range(5, 1);
        queue_frame(pick_word(), pick_word(), start, 1'b0, 1'b0, n);
        need_start = 1'b1;
      end else begin
        n = $urandom_range(3, 1);
        for (int i = 0; i < n; i++) begin
          queue_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
        end
        need_start = 1'b1;
      end
      added += n;
    end
  endtask

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_fire) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= pending_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    in_fire <= in_valid && in_ready;
    if (!rst && in_valid && in_ready) begin
      decode_byte(in_data);
      bytes_taken++;
    end
    if (!rst && out_valid && out_ready) begin
      if (expected_readings.size() == 0) begin
        $display("%0t: unexpected result beat, raw_temperature %h raw_humidity %h",
                 $time, out_data.raw_temperature, out_data.raw_humidity);
        failed = 1'b1;
      end else begin
        check_reading(expected_readings.pop_front(), out_data);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Extremes with good checksums, the second frame relying on the wrap.
    queue_frame(16'h0000, 16'h0000, 1'b1, 1'b0, 1'b0, 6);
    queue_frame(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0, 6);
    // A lone byte is dropped when the next frame carries a start mark.
    queue_frame(16'h1234, 16'h5678, 1'b1, 1'b0, 1'b0, 1);
    // Both checksums wrong reports the temperature error.
    queue_frame(16'h6666, 16'h8000, 1'b1, 1'b1, 1'b1, 6);
    queue_frame(16'h8001, 16'h7FFE, 1'b0, 1'b0, 1'b1, 6);
    queue_random(PHASE_BYTES - 25);
    wait (bytes_taken == bytes_queued);

    src_idle_pct = 80;
    sink_idle_pct = 29;
    queue_random(PHASE_BYTES);
    wait (bytes_taken == bytes_queued);

    src_idle_pct = 0;
    sink_idle_pct = 0;
    queue_random(PHASE_BYTES);
    wait (bytes_taken == bytes_queued);

    wait (expected_readings.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed && expected_readings.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
